@@ sv/doubly_linked_list_engine_assert.svh @@
// ---------------------------------------------------------------------------
// doubly_linked_list_engine assertion macros
// Concurrent check wrappers, compiled out for synthesis.
// ---------------------------------------------------------------------------
`ifndef DOUBLY_LINKED_LIST_ENGINE_ASSERT_SVH
`define DOUBLY_LINKED_LIST_ENGINE_ASSERT_SVH

`ifndef SYNTHESIS

`define DLLE_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`define DLLE_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define DLLE_ASSERT_IMP(label, ante, cons, msg)

`define DLLE_ASSERT_NXT(label, ante, cons, msg)

`endif

`endif

@@ sv/dlle_pkg.sv @@
// ---------------------------------------------------------------------------
// dlle_pkg
// Shared constants, codes and controller/datapath interface types.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package dlle_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 32;
  localparam int FUNC_W   = 3;
  localparam int STATUS_W = 2;

  // request codes
  localparam logic [FUNC_W-1:0] FN_INS_FRONT  = 3'd0;
  localparam logic [FUNC_W-1:0] FN_INS_END    = 3'd1;
  localparam logic [FUNC_W-1:0] FN_INS_BEFORE = 3'd2;
  localparam logic [FUNC_W-1:0] FN_DELETE     = 3'd3;
  localparam logic [FUNC_W-1:0] FN_LIST       = 3'd4;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd3;

  typedef enum logic [1:0] {
    RD_CUR,
    RD_HEAD,
    RD_NEXT
  } rd_src_t;

  typedef enum logic [1:0] {
    SEL_NODE,
    SEL_VAL,
    SEL_KEY,
    SEL_ZERO
  } out_sel_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LINK_FRONT,
    OP_LINK_END,
    OP_LINK_MID1,
    OP_LINK_MID2,
    OP_UNLINK
  } dp_op_t;

  typedef struct packed {
    logic                in_load;
    rd_src_t             rd_src;
    logic                cur_load;
    logic                k_clr;
    logic                k_inc;
    logic                nb_load;
    logic                alloc;
    dp_op_t              op;
    logic                out_load;
    logic [STATUS_W-1:0] out_status;
    out_sel_t            out_sel;
    logic                out_last;
  } dlle_cmd_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              count_zero;
    logic              full;
    logic              key_match;
    logic              k_last;
    logic              at_head;
    logic              out_free;
  } dlle_sts_t;

endpackage

@@ sv/dlle_ram.sv @@
// ---------------------------------------------------------------------------
// dlle_ram
// Generic single write port, single read port RAM with registered read.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module dlle_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rd_data_r <= mem_r[raddr];
  end

  assign rd_data = rd_data_r;

endmodule

@@ sv/dlle_datapath.sv @@
// ---------------------------------------------------------------------------
// dlle_datapath
// Node pool memories, list pointers, walk cursor and result register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module dlle_datapath (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  dlle_pkg::dlle_cmd_t                   cmd,
  output dlle_pkg::dlle_sts_t                   sts,
  input  logic [dlle_pkg::FUNC_W-1:0]           in_func,
  input  logic signed [dlle_pkg::DATA_W-1:0]    in_search_key,
  input  logic signed [dlle_pkg::DATA_W-1:0]    in_new_value,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [dlle_pkg::STATUS_W-1:0]         out_status,
  output logic signed [dlle_pkg::DATA_W-1:0]    out_value_out,
  output logic                                  out_last
);

  import dlle_pkg::*;

  // request registers
  logic [FUNC_W-1:0]        func_r;
  logic signed [DATA_W-1:0] key_r;
  logic signed [DATA_W-1:0] val_r;

  // list pointers
  logic [IDX_W-1:0] head_r;
  logic [IDX_W-1:0] tail_r;
  logic [IDX_W-1:0] free_head_r;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] fresh_r;

  // walk and edit scratch
  logic [IDX_W-1:0] cur_r;
  logic [IDX_W-1:0] k_r;
  logic [IDX_W-1:0] node_r;
  logic [IDX_W-1:0] before_r;
  logic [IDX_W-1:0] after_r;

  // result register
  logic                     out_valid_r;
  logic [STATUS_W-1:0]      out_status_r;
  logic signed [DATA_W-1:0] out_value_r;
  logic                     out_last_r;

  logic [IDX_W-1:0]  rd_addr;
  logic [DATA_W-1:0] rd_val;
  logic [IDX_W-1:0]  rd_next;
  logic [IDX_W-1:0]  rd_prev;
  logic [IDX_W-1:0]  rd_free;

  logic              val_we;
  logic              nxt_we;
  logic [IDX_W-1:0]  nxt_waddr;
  logic [IDX_W-1:0]  nxt_wdata;
  logic              prv_we;
  logic [IDX_W-1:0]  prv_waddr;
  logic [IDX_W-1:0]  prv_wdata;
  logic              free_we;

  logic count_zero;
  logic at_head;
  logic at_tail;
  logic stack_avail;
  logic out_free;
  logic signed [DATA_W-1:0] out_value_sel;

  assign count_zero  = (count_r == '0);
  assign at_head     = (cur_r == head_r);
  assign at_tail     = (cur_r == tail_r);
  // freed nodes sit on the stack; untouched nodes are handed out in order
  assign stack_avail = (fresh_r != count_r);
  assign out_free    = !out_valid_r || out_ready;

  always_comb begin
    case (cmd.rd_src)
      RD_CUR:  rd_addr = cur_r;
      RD_HEAD: rd_addr = head_r;
      RD_NEXT: rd_addr = rd_next;
      default: rd_addr = cur_r;
    endcase
  end

  always_comb begin
    val_we    = 1'b0;
    nxt_we    = 1'b0;
    nxt_waddr = node_r;
    nxt_wdata = node_r;
    prv_we    = 1'b0;
    prv_waddr = node_r;
    prv_wdata = node_r;
    free_we   = 1'b0;
    case (cmd.op)
      OP_LINK_FRONT: begin
        val_we    = 1'b1;
        nxt_we    = !count_zero;
        nxt_waddr = node_r;
        nxt_wdata = head_r;
        prv_we    = !count_zero;
        prv_waddr = head_r;
        prv_wdata = node_r;
      end
      OP_LINK_END: begin
        val_we    = 1'b1;
        nxt_we    = !count_zero;
        nxt_waddr = tail_r;
        nxt_wdata = node_r;
        prv_we    = !count_zero;
        prv_waddr = node_r;
        prv_wdata = tail_r;
      end
      OP_LINK_MID1: begin
        val_we    = 1'b1;
        nxt_we    = 1'b1;
        nxt_waddr = before_r;
        nxt_wdata = node_r;
        prv_we    = 1'b1;
        prv_waddr = node_r;
        prv_wdata = before_r;
      end
      OP_LINK_MID2: begin
        nxt_we    = 1'b1;
        nxt_waddr = node_r;
        nxt_wdata = cur_r;
        prv_we    = 1'b1;
        prv_waddr = cur_r;
        prv_wdata = node_r;
      end
      OP_UNLINK: begin
        nxt_we    = !at_head;
        nxt_waddr = before_r;
        nxt_wdata = after_r;
        prv_we    = !at_tail;
        prv_waddr = after_r;
        prv_wdata = before_r;
        free_we   = 1'b1;
      end
      default: begin
        val_we = 1'b0;
      end
    endcase
  end

  dlle_ram #(.WIDTH(DATA_W), .DEPTH(CAPACITY)) u_val_ram (
    .clk     (clk),
    .we      (val_we),
    .waddr   (node_r),
    .wdata   (val_r),
    .raddr   (rd_addr),
    .rd_data (rd_val)
  );

  dlle_ram #(.WIDTH(IDX_W), .DEPTH(CAPACITY)) u_nxt_ram (
    .clk     (clk),
    .we      (nxt_we),
    .waddr   (nxt_waddr),
    .wdata   (nxt_wdata),
    .raddr   (rd_addr),
    .rd_data (rd_next)
  );

  dlle_ram #(.WIDTH(IDX_W), .DEPTH(CAPACITY)) u_prv_ram (
    .clk     (clk),
    .we      (prv_we),
    .waddr   (prv_waddr),
    .wdata   (prv_wdata),
    .raddr   (rd_addr),
    .rd_data (rd_prev)
  );

  // free stack links, always reading the entry under the stack top
  dlle_ram #(.WIDTH(IDX_W), .DEPTH(CAPACITY)) u_free_ram (
    .clk     (clk),
    .we      (free_we),
    .waddr   (cur_r),
    .wdata   (free_head_r),
    .raddr   (free_head_r),
    .rd_data (rd_free)
  );

  always_comb begin
    case (cmd.out_sel)
      SEL_NODE: out_value_sel = rd_val;
      SEL_VAL:  out_value_sel = val_r;
      SEL_KEY:  out_value_sel = key_r;
      SEL_ZERO: out_value_sel = '0;
      default:  out_value_sel = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      tail_r      <= '0;
      free_head_r <= '0;
      count_r     <= '0;
      fresh_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.alloc) begin
        if (stack_avail) begin
          free_head_r <= rd_free;
        end else begin
          fresh_r <= fresh_r + CNT_W'(1);
        end
      end
      case (cmd.op)
        OP_LINK_FRONT: begin
          head_r  <= node_r;
          if (count_zero) begin
            tail_r <= node_r;
          end
          count_r <= count_r + CNT_W'(1);
        end
        OP_LINK_END: begin
          tail_r  <= node_r;
          if (count_zero) begin
            head_r <= node_r;
          end
          count_r <= count_r + CNT_W'(1);
        end
        OP_LINK_MID2: begin
          count_r <= count_r + CNT_W'(1);
        end
        OP_UNLINK: begin
          if (at_head) begin
            head_r <= after_r;
          end
          if (at_tail) begin
            tail_r <= before_r;
          end
          free_head_r <= cur_r;
          count_r     <= count_r - CNT_W'(1);
        end
        default: begin
          count_r <= count_r;
        end
      endcase
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.in_load) begin
      func_r <= in_func;
      key_r  <= in_search_key;
      val_r  <= in_new_value;
    end
    if (cmd.cur_load) begin
      cur_r <= rd_addr;
    end
    if (cmd.k_clr) begin
      k_r <= '0;
    end else if (cmd.k_inc) begin
      k_r <= k_r + IDX_W'(1);
    end
    if (cmd.nb_load) begin
      before_r <= rd_prev;
      after_r  <= rd_next;
    end
    if (cmd.alloc) begin
      node_r <= stack_avail ? free_head_r : fresh_r[IDX_W-1:0];
    end
    if (cmd.out_load) begin
      out_status_r <= cmd.out_status;
      out_value_r  <= out_value_sel;
      out_last_r   <= cmd.out_last;
    end
  end

  assign sts.func       = func_r;
  assign sts.count_zero = count_zero;
  assign sts.full       = (count_r == CNT_W'(CAPACITY));
  assign sts.key_match  = (rd_val == key_r);
  assign sts.k_last     = ((CNT_W'(k_r) + CNT_W'(1)) == count_r);
  assign sts.at_head    = at_head;
  assign sts.out_free   = out_free;

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_value_out = out_value_r;
  assign out_last      = out_last_r;

endmodule

@@ sv/dlle_ctrl.sv @@
// ---------------------------------------------------------------------------
// dlle_ctrl
// Request sequencer: decode, key search, allocate, relink, list walk and result issue.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module dlle_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  dlle_pkg::dlle_sts_t sts,
  output dlle_pkg::dlle_cmd_t cmd
);

  import dlle_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_SEARCH,
    S_ALLOC,
    S_LINK1,
    S_LINK2,
    S_UNLINK,
    S_LIST,
    S_RESP
  } state_t;

  typedef enum logic [1:0] {
    K_FRONT,
    K_END,
    K_MID
  } kind_t;

  state_t              state_r,       state_nxt;
  kind_t               kind_r,        kind_nxt;
  logic [STATUS_W-1:0] resp_status_r, resp_status_nxt;
  out_sel_t            resp_sel_r,    resp_sel_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt       = state_r;
    kind_nxt        = kind_r;
    resp_status_nxt = resp_status_r;
    resp_sel_nxt    = resp_sel_r;

    cmd.in_load    = 1'b0;
    cmd.rd_src     = RD_CUR;
    cmd.cur_load   = 1'b0;
    cmd.k_clr      = 1'b0;
    cmd.k_inc      = 1'b0;
    cmd.nb_load    = 1'b0;
    cmd.alloc      = 1'b0;
    cmd.op         = OP_NONE;
    cmd.out_load   = 1'b0;
    cmd.out_status = ST_OK;
    cmd.out_sel    = SEL_NODE;
    cmd.out_last   = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.in_load = 1'b1;
          state_nxt   = S_DECODE;
        end
      end

      S_DECODE: begin
        case (sts.func)
          FN_INS_FRONT, FN_INS_END: begin
            if (sts.full) begin
              resp_status_nxt = ST_FULL;
              resp_sel_nxt    = SEL_VAL;
              state_nxt       = S_RESP;
            end else begin
              kind_nxt  = (sts.func == FN_INS_FRONT) ? K_FRONT : K_END;
              state_nxt = S_ALLOC;
            end
          end
          FN_INS_BEFORE, FN_DELETE: begin
            if (sts.count_zero) begin
              resp_status_nxt = ST_EMPTY;
              resp_sel_nxt    = SEL_KEY;
              state_nxt       = S_RESP;
            end else begin
              cmd.rd_src   = RD_HEAD;
              cmd.cur_load = 1'b1;
              cmd.k_clr    = 1'b1;
              state_nxt    = S_SEARCH;
            end
          end
          FN_LIST: begin
            if (sts.count_zero) begin
              resp_status_nxt = ST_EMPTY;
              resp_sel_nxt    = SEL_ZERO;
              state_nxt       = S_RESP;
            end else begin
              cmd.rd_src   = RD_HEAD;
              cmd.cur_load = 1'b1;
              cmd.k_clr    = 1'b1;
              state_nxt    = S_LIST;
            end
          end
          default: begin
            // unused codes produce no result
            state_nxt = S_IDLE;
          end
        endcase
      end

      S_SEARCH: begin
        if (sts.key_match) begin
          cmd.nb_load = 1'b1;
          if (sts.func == FN_DELETE) begin
            state_nxt = S_UNLINK;
          end else if (sts.full) begin
            resp_status_nxt = ST_FULL;
            resp_sel_nxt    = SEL_VAL;
            state_nxt       = S_RESP;
          end else begin
            kind_nxt  = sts.at_head ? K_FRONT : K_MID;
            state_nxt = S_ALLOC;
          end
        end else if (sts.k_last) begin
          resp_status_nxt = ST_NOTFOUND;
          resp_sel_nxt    = SEL_KEY;
          state_nxt       = S_RESP;
        end else begin
          // follow the forward link, read issued this cycle
          cmd.rd_src   = RD_NEXT;
          cmd.cur_load = 1'b1;
          cmd.k_inc    = 1'b1;
        end
      end

      S_ALLOC: begin
        cmd.alloc = 1'b1;
        state_nxt = S_LINK1;
      end

      S_LINK1: begin
        resp_status_nxt = ST_OK;
        resp_sel_nxt    = SEL_VAL;
        case (kind_r)
          K_FRONT: begin
            cmd.op    = OP_LINK_FRONT;
            state_nxt = S_RESP;
          end
          K_END: begin
            cmd.op    = OP_LINK_END;
            state_nxt = S_RESP;
          end
          K_MID: begin
            cmd.op    = OP_LINK_MID1;
            state_nxt = S_LINK2;
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end

      S_LINK2: begin
        cmd.op    = OP_LINK_MID2;
        state_nxt = S_RESP;
      end

      S_UNLINK: begin
        cmd.op          = OP_UNLINK;
        resp_status_nxt = ST_OK;
        resp_sel_nxt    = SEL_KEY;
        state_nxt       = S_RESP;
      end

      S_LIST: begin
        if (sts.out_free) begin
          cmd.out_load   = 1'b1;
          cmd.out_status = ST_OK;
          cmd.out_sel    = SEL_NODE;
          cmd.out_last   = sts.k_last;
          if (sts.k_last) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.rd_src   = RD_NEXT;
            cmd.cur_load = 1'b1;
            cmd.k_inc    = 1'b1;
          end
        end
      end

      S_RESP: begin
        if (sts.out_free) begin
          cmd.out_load   = 1'b1;
          cmd.out_status = resp_status_r;
          cmd.out_sel    = resp_sel_r;
          cmd.out_last   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      kind_r        <= K_FRONT;
      resp_status_r <= ST_OK;
      resp_sel_r    <= SEL_NODE;
    end else begin
      state_r       <= state_nxt;
      kind_r        <= kind_nxt;
      resp_status_r <= resp_status_nxt;
      resp_sel_r    <= resp_sel_nxt;
    end
  end

endmodule

@@ sv/doubly_linked_list_engine.sv @@
// ---------------------------------------------------------------------------
// doubly_linked_list_engine
// Ordered list of signed 32-bit values held in a 16-node linked pool.
// Input channel (in_valid/in_ready): in_func selects insert front, insert
// end, insert before key, delete key or list; in_search_key and
// in_new_value carry the operands. One request is in flight at a time.
// Result channel (out_valid/out_ready): out_status, out_value_out and
// out_last; list requests give one item per element, other defined requests one item.
// Insert front/end allocate a node and relink; delete and insert before
// first search for the key, reading one node per cycle (up to 16 nodes),
// then a delete unlinks the node and an insert allocates and relinks, with
// an extra link step unless the key is at the head. An empty list, missing
// key or full pool gives a status reply and no edit.
// A list request streams one element per cycle while the result register
// is free. Undefined request codes give no result and free the input.
// Reset empties the list at once; no memory clearing pass is needed.
// The result register holds a pending item while out_ready is low; the
// next request is accepted meanwhile and waits only to hand its result on.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "doubly_linked_list_engine_assert.svh"

module doubly_linked_list_engine (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [dlle_pkg::FUNC_W-1:0]           in_func,
  input  logic signed [dlle_pkg::DATA_W-1:0]    in_search_key,
  input  logic signed [dlle_pkg::DATA_W-1:0]    in_new_value,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [dlle_pkg::STATUS_W-1:0]         out_status,
  output logic signed [dlle_pkg::DATA_W-1:0]    out_value_out,
  output logic                                  out_last
);

  import dlle_pkg::*;

  dlle_cmd_t cmd;
  dlle_sts_t sts;

  dlle_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  dlle_datapath u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_func       (in_func),
    .in_search_key (in_search_key),
    .in_new_value  (in_new_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_status    (out_status),
    .out_value_out (out_value_out),
    .out_last      (out_last)
  );

  `DLLE_ASSERT_IMP(a_load_into_free_slot, cmd.out_load, sts.out_free, "result overwritten")
  `DLLE_ASSERT_IMP(a_alloc_has_room, cmd.alloc, !sts.full, "node taken from full pool")
  `DLLE_ASSERT_IMP(a_unlink_live_list, cmd.op == OP_UNLINK, !sts.count_zero, "unlink on empty")
  `DLLE_ASSERT_NXT(a_one_item_in_flight, in_valid && in_ready, !in_ready, "second item taken")

endmodule

@@ bench/tb_top.sv @@
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for doubly_linked_list_engine. A queue of requests
// feeds a valid/ready driver; a shadow copy of the node pool, links and free
// chain predicts every result, and the monitor checks each result item in
// order. Directed corner requests come first, then randomized fill, drain
// and mixed episodes with idle and stall bursts on both channels.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  import dlle_pkg::*;

  localparam int RANDOM_ITEMS  = 60;
  localparam int CALM_ITEMS    = 15;
  localparam int DRAIN_CYCLES  = 40;
  localparam int STALL_LIMIT   = 3000;
  localparam int PRINT_LIMIT   = 30;
  localparam int RECENT_DEPTH  = 12;

  // request codes the block ignores
  localparam logic [FUNC_W-1:0] FN_UNUSED_LO = 3'd5;
  localparam logic [FUNC_W-1:0] FN_UNUSED_HI = 3'd7;

  typedef enum int {
    EP_FILL,
    EP_DRAIN,
    EP_MIX
  } episode_t;

  typedef struct {
    logic [FUNC_W-1:0] func;
    logic [DATA_W-1:0] key;
    logic [DATA_W-1:0] val;
    int                gap;
    bit                calm;
  } list_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [DATA_W-1:0]   value;
    logic                last;
  } list_result_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [FUNC_W-1:0]        in_func = '0;
  logic signed [DATA_W-1:0] in_search_key = '0;
  logic signed [DATA_W-1:0] in_new_value = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic [STATUS_W-1:0]      out_status;
  logic signed [DATA_W-1:0] out_value_out;
  logic                     out_last;

  doubly_linked_list_engine dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_func       (in_func),
    .in_search_key (in_search_key),
    .in_new_value  (in_new_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_status    (out_status),
    .out_value_out (out_value_out),
    .out_last      (out_last)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // shadow of the list held by the block
  logic [DATA_W-1:0] node_val [CAPACITY];
  logic [IDX_W-1:0]  fwd_link [CAPACITY];
  logic [IDX_W-1:0]  back_link [CAPACITY];
  logic [IDX_W-1:0]  spare_link [CAPACITY];
  logic [IDX_W-1:0]  head_at;
  logic [IDX_W-1:0]  tail_at;
  logic [IDX_W-1:0]  spare_head;
  int                live_count;
  int                peak_count;

  list_req_t         req_pending [$];
  list_result_t      results_due [$];
  logic [DATA_W-1:0] recent_vals [$];

  int reqs_made;
  int reqs_taken;
  int results_checked;
  int mismatches;
  int seen_full;
  int seen_missing;
  int seen_empty;

  list_req_t stage;
  bit        staged;
  int        stage_gap;
  bit        rx_calm = 1'b0;
  bit        rx_bursty;
  int        rx_span;
  int        rx_hold;
  int        quiet_cycles;

  task automatic flag_mismatch(input string what);
    if (mismatches < PRINT_LIMIT) begin
      $display("%0t mismatch: %s", $realtime, what);
    end
    mismatches++;
  endtask

  function automatic void post_result(logic [STATUS_W-1:0] st, logic [DATA_W-1:0] v,
                                      logic lst);
    list_result_t r;
    r.status = st;
    r.value  = v;
    r.last   = lst;
    results_due.push_back(r);
  endfunction

  function automatic logic [IDX_W-1:0] grab_node(logic [DATA_W-1:0] v);
    logic [IDX_W-1:0] n;
    n = spare_head;
    spare_head = spare_link[n];
    node_val[n] = v;
    live_count++;
    if (live_count > peak_count) peak_count = live_count;
    return n;
  endfunction

  function automatic void link_front(logic [DATA_W-1:0] v);
    logic [IDX_W-1:0] n;
    n = grab_node(v);
    if (live_count == 1) begin
      tail_at = n;
    end else begin
      fwd_link[n] = head_at;
      back_link[head_at] = n;
    end
    back_link[n] = n;
    head_at = n;
  endfunction

  function automatic void link_end(logic [DATA_W-1:0] v);
    logic [IDX_W-1:0] n;
    n = grab_node(v);
    if (live_count == 1) begin
      head_at = n;
      back_link[n] = n;
    end else begin
      fwd_link[tail_at] = n;
      back_link[n] = tail_at;
    end
    fwd_link[n] = n;
    tail_at = n;
  endfunction

  function automatic bit find_first(logic [DATA_W-1:0] key, output logic [IDX_W-1:0] pos);
    logic [IDX_W-1:0] p;
    p = head_at;
    pos = '0;
    for (int k = 0; k < live_count; k++) begin
      if (node_val[p] == key) begin
        pos = p;
        return 1'b1;
      end
      p = fwd_link[p];
    end
    return 1'b0;
  endfunction

  // work out the result items of one accepted request and update the shadow
  function automatic void apply_list_request(logic [FUNC_W-1:0] func, logic [DATA_W-1:0] key,
                                             logic [DATA_W-1:0] val);
    logic [IDX_W-1:0] p;
    logic [IDX_W-1:0] prior;
    logic [IDX_W-1:0] after;
    logic [IDX_W-1:0] n;
    case (func)
      FN_INS_FRONT, FN_INS_END: begin
        if (live_count >= CAPACITY) begin
          post_result(ST_FULL, val, 1'b1);
        end else begin
          if (func == FN_INS_FRONT) link_front(val);
          else link_end(val);
          post_result(ST_OK, val, 1'b1);
        end
      end
      FN_INS_BEFORE: begin
        if (live_count == 0) begin
          post_result(ST_EMPTY, key, 1'b1);
        end else if (!find_first(key, p)) begin
          post_result(ST_NOTFOUND, key, 1'b1);
        end else if (live_count >= CAPACITY) begin
          post_result(ST_FULL, val, 1'b1);
        end else begin
          if (p == head_at) begin
            link_front(val);
          end else begin
            prior = back_link[p];
            n = grab_node(val);
            fwd_link[prior] = n;
            back_link[n] = prior;
            fwd_link[n] = p;
            back_link[p] = n;
          end
          post_result(ST_OK, val, 1'b1);
        end
      end
      FN_DELETE: begin
        if (live_count == 0) begin
          post_result(ST_EMPTY, key, 1'b1);
        end else if (!find_first(key, p)) begin
          post_result(ST_NOTFOUND, key, 1'b1);
        end else begin
          prior = back_link[p];
          after = fwd_link[p];
          if (p == head_at) head_at = after;
          else fwd_link[prior] = after;
          if (p == tail_at) tail_at = prior;
          else back_link[after] = prior;
          spare_link[p] = spare_head;
          spare_head = p;
          live_count--;
          if (live_count == 0) begin
            head_at = '0;
            tail_at = '0;
          end
          post_result(ST_OK, key, 1'b1);
        end
      end
      FN_LIST: begin
        if (live_count == 0) begin
          post_result(ST_EMPTY, '0, 1'b1);
        end else begin
          p = head_at;
          for (int k = 0; k < live_count; k++) begin
            post_result(ST_OK, node_val[p], k + 1 == live_count);
            p = fwd_link[p];
          end
        end
      end
      default: begin
        // undefined codes leave everything as it is
      end
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] pick_corner();
    case ($urandom_range(0, 6))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      4: return 32'h0000_0001;
      5: return 32'h0000_0002;
      default: return 32'h0000_0003;
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] pick_value();
    if ($urandom_range(0, 3) == 0) return $urandom;
    return pick_corner();
  endfunction

  // keys mostly reuse recently stored values so searches tend to hit
  function automatic logic [DATA_W-1:0] pick_key();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6 && recent_vals.size() != 0)
      return recent_vals[$urandom_range(0, recent_vals.size() - 1)];
    if (r < 8) return pick_corner();
    return $urandom;
  endfunction

  function automatic logic [FUNC_W-1:0] choose_func(episode_t kind, bit inserts_only);
    int r;
    r = inserts_only ? $urandom_range(0, 84) : $urandom_range(0, 99);
    case (kind)
      EP_FILL: begin
        if (r < 30) return FN_INS_FRONT;
        if (r < 60) return FN_INS_END;
        if (r < 85) return FN_INS_BEFORE;
        if (r < 92) return FN_DELETE;
        if (r < 97) return FN_LIST;
      end
      EP_DRAIN: begin
        if (r < 10) return FN_INS_FRONT;
        if (r < 20) return FN_INS_END;
        if (r < 28) return FN_INS_BEFORE;
        if (r < 85) return FN_DELETE;
        if (r < 95) return FN_LIST;
      end
      default: begin
        if (r < 18) return FN_INS_FRONT;
        if (r < 36) return FN_INS_END;
        if (r < 54) return FN_INS_BEFORE;
        if (r < 80) return FN_DELETE;
        if (r < 95) return FN_LIST;
      end
    endcase
    return FUNC_W'($urandom_range(FN_UNUSED_LO, FN_UNUSED_HI));
  endfunction

  task automatic queue_request(input logic [FUNC_W-1:0] f, input logic [DATA_W-1:0] k,
                               input logic [DATA_W-1:0] v, input bit idle_on, input bit calm);
    list_req_t r;
    r.func = f;
    r.key  = k;
    r.val  = v;
    r.calm = calm;
    r.gap  = (idle_on && !calm && $urandom_range(0, 2) == 0) ? $urandom_range(1, 11) : 0;
    req_pending.push_back(r);
    reqs_made++;
    if (f == FN_INS_FRONT || f == FN_INS_END || f == FN_INS_BEFORE) begin
      recent_vals.push_back(v);
      if (recent_vals.size() > RECENT_DEPTH) void'(recent_vals.pop_front());
    end
  endtask

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        apply_list_request(in_func, in_search_key, in_new_value);
        reqs_taken++;
      end
      if (!in_valid || in_ready) begin
        if (!staged && req_pending.size() != 0) begin
          stage = req_pending.pop_front();
          stage_gap = stage.gap;
          staged = 1'b1;
        end
        if (staged && stage_gap == 0) begin
          in_valid      <= 1'b1;
          in_func       <= stage.func;
          in_search_key <= stage.key;
          in_new_value  <= stage.val;
          rx_calm       <= rx_calm | stage.calm;
          staged = 1'b0;
        end else begin
          in_valid <= 1'b0;
          if (staged) stage_gap--;
        end
      end
    end
  end

  // result monitor and receiver stalls
  always @(posedge clk) begin
    list_result_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (results_due.size() == 0) begin
          flag_mismatch($sformatf("unexpected item status=%0d value=%0d last=%0b",
                                  out_status, out_value_out, out_last));
        end else begin
          want = results_due.pop_front();
          if (out_status !== want.status)
            flag_mismatch($sformatf("status %0d, want %0d", out_status, want.status));
          if (out_value_out !== want.value)
            flag_mismatch($sformatf("value %0d, want %0d", out_value_out, $signed(want.value)));
          if (out_last !== want.last)
            flag_mismatch($sformatf("last %0b, want %0b", out_last, want.last));
          results_checked++;
          case (want.status)
            ST_FULL: seen_full++;
            ST_NOTFOUND: seen_missing++;
            ST_EMPTY: seen_empty++;
            default: ;
          endcase
        end
      end
      // alternate stretches with and without stall bursts
      if (rx_span == 0) begin
        rx_span = $urandom_range(40, 200);
        rx_bursty = $urandom_range(0, 2) != 0;
      end else begin
        rx_span--;
      end
      if (rx_hold > 0) begin
        rx_hold--;
        out_ready <= 1'b0;
      end else if (!rx_calm && rx_bursty && $urandom_range(0, 4) == 0) begin
        rx_hold = $urandom_range(0, 10);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // watchdog on handshake activity
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    int rand_items;
    int len;
    bit first;
    bit idle_on;
    episode_t kind;
    logic [FUNC_W-1:0] f;

    for (int i = 0; i < CAPACITY; i++) begin
      node_val[i]   = '0;
      fwd_link[i]   = '0;
      back_link[i]  = '0;
      spare_link[i] = (i + 1 < CAPACITY) ? IDX_W'(i + 1) : '0;
    end
    head_at = '0;
    tail_at = '0;
    spare_head = '0;
    live_count = 0;
    peak_count = 0;

    // directed corners: empty list, extremes, head/middle/tail/only deletes
    queue_request(FN_LIST, 32'h0, 32'h0, 1, 0);
    queue_request(FN_DELETE, 32'h5, 32'h0, 1, 0);
    queue_request(FN_INS_BEFORE, 32'h5, 32'h9, 1, 0);
    for (int c = FN_UNUSED_LO; c <= FN_UNUSED_HI; c++)
      queue_request(FUNC_W'(c), 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 0);
    queue_request(FN_INS_FRONT, 32'h0, 32'h7FFF_FFFF, 1, 0);
    queue_request(FN_INS_END, 32'h0, 32'h8000_0000, 1, 0);
    queue_request(FN_INS_BEFORE, 32'h8000_0000, 32'h0, 1, 0);
    queue_request(FN_INS_BEFORE, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1, 0);
    queue_request(FN_INS_BEFORE, 32'd1234, 32'd77, 1, 0);
    queue_request(FN_DELETE, 32'd1234, 32'd0, 1, 0);
    queue_request(FN_INS_END, 32'h0, 32'hFFFF_FFFF, 1, 0);
    queue_request(FN_LIST, 32'h0, 32'h0, 1, 0);
    queue_request(FN_DELETE, 32'hFFFF_FFFF, 32'h0, 1, 0);
    queue_request(FN_DELETE, 32'hFFFF_FFFF, 32'h0, 1, 0);
    queue_request(FN_DELETE, 32'h0, 32'h0, 1, 0);
    queue_request(FN_DELETE, 32'h8000_0000, 32'h0, 1, 0);
    queue_request(FN_DELETE, 32'h7FFF_FFFF, 32'h0, 1, 0);
    queue_request(FN_LIST, 32'h0, 32'h0, 1, 0);
    queue_request(FN_INS_END, 32'h0, 32'h5A5A_5A5A, 1, 0);
    queue_request(FN_INS_FRONT, 32'h0, 32'hA5A5_A5A5, 1, 0);
    queue_request(FN_LIST, 32'h0, 32'h0, 1, 0);
    queue_request(FN_DELETE, 32'h5A5A_5A5A, 32'h0, 1, 0);
    queue_request(FN_DELETE, 32'hA5A5_A5A5, 32'h0, 1, 0);

    // random episodes; the first one only inserts, so the pool fills up
    rand_items = 0;
    first = 1'b1;
    while (rand_items < RANDOM_ITEMS) begin
      kind = first ? EP_FILL : episode_t'($urandom_range(0, 2));
      len = first ? 19 : $urandom_range(8, 20);
      idle_on = $urandom_range(0, 2) != 0;
      for (int j = 0; j < len; j++) begin
        f = choose_func(kind, first);
        queue_request(f, pick_key(), pick_value(), idle_on, 0);
        if (f <= FN_LIST) rand_items++;
      end
      queue_request(FN_LIST, $urandom, $urandom, idle_on, 0);
      rand_items++;
      first = 1'b0;
    end

    // closing stretch runs with no idling on either side
    for (int j = 0; j < CALM_ITEMS; j++)
      queue_request(choose_func(EP_MIX, 0), pick_key(), pick_value(), 0, 1);
    queue_request(FN_LIST, 32'h0, 32'h0, 0, 1);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    while (reqs_taken < reqs_made) @(posedge clk);
    while (results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d requests and %0d result items, list length up to %0d",
             reqs_taken, results_checked, peak_count);
    $display("replies seen: %0d pool full, %0d key missing, %0d list empty",
             seen_full, seen_missing, seen_empty);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
